// ----- design/dhkt_pkg.sv -----
// Shared types and constants of the double-hash key table.
package dhkt_pkg;

    localparam int HASH_W   = 18;
    localparam int PROD_W   = 24;
    localparam int DIGIT_W  = 3;
    localparam int STEP_CNT = PROD_W / DIGIT_W;
    localparam int STEP_W   = $clog2(STEP_CNT);
    localparam int LEN_W    = 6;
    localparam int COUNT_W  = 16;
    localparam int COLL_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [HASH_W-1:0] SEED_START = 18'd181243;
    localparam logic [HASH_W-1:0] SEED_STEP  = 18'd4273;
    localparam logic [PROD_W-1:0] HASH_MUL   = 24'd47;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LONG  = 2'd3
    } status_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_FILL  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage

// ----- design/double_hash_key_table.sv -----
// Top level of the double-hash key table: key intake, probe sequencer, result register.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata key_char, tuser op, tlast key_last
//  m_      | out | m_tvalid/m_tready  | tdata status, slot_index, record_count,
//          |     |                    |       new_key, collision_total
//
// Each key byte is run through the three-bit-per-cycle modulo reduction before the
// next byte is taken. Each probe passes S_WAIT and S_CMP for every key word compared;
// an insert then writes the key words one by one in S_FILL. Slot state sits in RAMs
// with registered reads. After reset a clearing pass over all TABLE_SIZE slots empties
// them; s_tready stays low meanwhile. A waiting result stalls the next key in S_DONE.
module double_hash_key_table #(
    parameter int TABLE_SIZE    = 16381,
    parameter int MAX_KEY_CHARS = 59
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic [7:0] s_tdata,   // key_char
    input  logic s_tuser,         // op
    input  logic s_tlast,         // key_last
    output logic m_tvalid,
    input  logic m_tready,
    // status, slot_index, record_count, new_key, collision_total, zero pad
    output logic [((51 + $clog2(TABLE_SIZE) + 7) / 8) * 8 - 1:0] m_tdata
);
    import dhkt_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SIZE);
    localparam int KW      = (MAX_KEY_CHARS + 7) / 8;
    localparam int KWW     = (KW > 1) ? $clog2(KW) : 1;
    localparam int OUT_W   = STATUS_W + SLOT_W + COUNT_W + 1 + COLL_W;
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    state_t state_reg, state_next;

    logic [HASH_W-1:0]  start_h_reg, start_h_next;
    logic [HASH_W-1:0]  step_h_reg, step_h_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic               op_reg, op_next;
    logic               last_reg, last_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  step_reg, step_next;
    logic [SLOT_W-1:0]  probe_reg, probe_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic [KWW-1:0]     w_reg, w_next;
    logic [COLL_W-1:0]  coll_reg, coll_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic               res_new_reg, res_new_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [63:0]        kw_reg [KW];

    logic               accept;
    logic               hash_start;
    logic               start_done;
    logic               step_done;
    logic [SLOT_W-1:0]  start_res;
    logic [SLOT_W-1:0]  step_res;

    logic                     meta_we;
    logic [SLOT_W-1:0]        meta_waddr;
    logic [LEN_W+COUNT_W-1:0] meta_wdata;
    logic [LEN_W+COUNT_W-1:0] meta_rdata;
    logic                     word_we;
    logic [63:0]              word_rdata;

    logic [LEN_W-1:0]   meta_len;
    logic [COUNT_W-1:0] meta_rec;
    logic [KWW-1:0]     last_w;
    logic [SLOT_W:0]    slot_sum;
    logic [SLOT_W-1:0]  slot_adv;
    logic [KWW-1:0]     byte_word;

    assign accept     = s_tvalid && s_tready;
    assign hash_start = accept;
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    assign meta_len  = meta_rdata[LEN_W+COUNT_W-1 -: LEN_W];
    assign meta_rec  = meta_rdata[COUNT_W-1:0];
    assign last_w    = KWW'((len_reg - 1'b1) >> 3);
    assign byte_word = KWW'(len_reg >> 3);
    assign slot_sum  = {1'b0, slot_reg} + {1'b0, step_reg};
    assign slot_adv  = (slot_sum >= (SLOT_W + 1)'(TABLE_SIZE)) ?
                       SLOT_W'(slot_sum - (SLOT_W + 1)'(TABLE_SIZE)) : SLOT_W'(slot_sum);

    dhkt_hash_unit #(.TABLE_SIZE(TABLE_SIZE)) u_start_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .h_in  (start_h_reg),
        .c     (s_tdata),
        .done  (start_done),
        .h_out (start_res)
    );

    dhkt_hash_unit #(.TABLE_SIZE(TABLE_SIZE)) u_step_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .h_in  (step_h_reg),
        .c     (s_tdata),
        .done  (step_done),
        .h_out (step_res)
    );

    dhkt_slot_mem #(.TABLE_SIZE(TABLE_SIZE), .KWW(KWW)) u_slot_mem (
        .clk        (clk),
        .meta_we    (meta_we),
        .meta_waddr (meta_waddr),
        .meta_wdata (meta_wdata),
        .meta_raddr (slot_reg),
        .meta_rdata (meta_rdata),
        .word_we    (word_we),
        .word_addr  ({slot_reg, w_reg}),
        .word_wdata (kw_reg[w_reg]),
        .word_rdata (word_rdata)
    );

    // Key bytes go straight into their word; the first byte of a word clears
    // the rest so that a short final word is zero padded.
    always_ff @(posedge clk)
    begin
        if (accept && (len_reg < LEN_W'(MAX_KEY_CHARS)))
        begin
            if (len_reg[2:0] == 3'd0)
            begin
                kw_reg[byte_word] <= {56'd0, s_tdata};
            end
            else
            begin
                kw_reg[byte_word][len_reg[2:0]*8 +: 8] <= s_tdata;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        start_h_next    = start_h_reg;
        step_h_next     = step_h_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        op_next         = op_reg;
        last_next       = last_reg;
        slot_next       = slot_reg;
        step_next       = step_reg;
        probe_next      = probe_reg;
        clr_next        = clr_reg;
        w_next          = w_reg;
        coll_next       = coll_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        res_new_next    = res_new_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        meta_we         = 1'b0;
        meta_waddr      = slot_reg;
        meta_wdata      = '0;
        word_we         = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = s_tuser;
                    last_next = s_tlast;
                    if (len_reg < LEN_W'(MAX_KEY_CHARS))
                    begin
                        len_next = len_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (start_done && step_done)
                begin
                    start_h_next = HASH_W'(start_res);
                    step_h_next  = HASH_W'(step_res);
                    if (!last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (ovf_reg)
                    begin
                        res_status_next = ST_TOO_LONG;
                        res_slot_next   = '0;
                        res_count_next  = '0;
                        res_new_next    = 1'b0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        slot_next  = start_res;
                        step_next  = step_res;
                        probe_next = '0;
                        w_next     = '0;
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                res_slot_next  = '0;
                res_count_next = '0;
                res_new_next   = 1'b0;
                if (meta_len == '0)
                begin
                    if (op_reg)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        meta_we         = 1'b1;
                        meta_wdata      = {len_reg, COUNT_W'(1)};
                        coll_next       = coll_reg + COLL_W'(probe_reg);
                        res_status_next = ST_OK;
                        res_slot_next   = slot_reg;
                        res_count_next  = COUNT_W'(1);
                        res_new_next    = 1'b1;
                        w_next          = '0;
                        state_next      = S_FILL;
                    end
                end
                else if ((meta_len == len_reg) && (word_rdata == kw_reg[w_reg]))
                begin
                    if (w_reg == last_w)
                    begin
                        res_status_next = ST_OK;
                        res_slot_next   = slot_reg;
                        res_count_next  = meta_rec;
                        if (!op_reg && (meta_rec != COUNT_MAX))
                        begin
                            meta_we        = 1'b1;
                            meta_wdata     = {meta_len, meta_rec + 1'b1};
                            res_count_next = meta_rec + 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        w_next     = w_reg + 1'b1;
                        state_next = S_WAIT;
                    end
                end
                else if (probe_reg == SLOT_W'(TABLE_SIZE - 1))
                begin
                    if (op_reg)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                        coll_next       = coll_reg + COLL_W'(TABLE_SIZE);
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    slot_next  = slot_adv;
                    w_next     = '0;
                    state_next = S_WAIT;
                end
            end
            S_FILL:
            begin
                word_we = 1'b1;
                if (w_reg == last_w)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    w_next = w_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = TDATA_W'({coll_reg, res_new_reg, res_count_reg,
                                              res_slot_reg, res_status_reg});
                    len_next      = '0;
                    ovf_next      = 1'b0;
                    start_h_next  = SEED_START;
                    step_h_next   = SEED_STEP;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            start_h_reg    <= SEED_START;
            step_h_reg     <= SEED_STEP;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            op_reg         <= 1'b0;
            last_reg       <= 1'b0;
            slot_reg       <= '0;
            step_reg       <= '0;
            probe_reg      <= '0;
            clr_reg        <= '0;
            w_reg          <= '0;
            coll_reg       <= '0;
            res_status_reg <= '0;
            res_slot_reg   <= '0;
            res_count_reg  <= '0;
            res_new_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            start_h_reg    <= start_h_next;
            step_h_reg     <= step_h_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            op_reg         <= op_next;
            last_reg       <= last_next;
            slot_reg       <= slot_next;
            step_reg       <= step_next;
            probe_reg      <= probe_next;
            clr_reg        <= clr_next;
            w_reg          <= w_next;
            coll_reg       <= coll_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_count_reg  <= res_count_next;
            res_new_reg    <= res_new_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
        end
    end

endmodule

// ----- design/dhkt_hash_unit.sv -----
// One hash step h = ((h ^ c) * 47) mod TABLE_SIZE, reduced three bits per cycle.
module dhkt_hash_unit #(
    parameter int TABLE_SIZE = 16381
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [dhkt_pkg::HASH_W-1:0]     h_in,
    input  logic [7:0]                      c,
    output logic                            done,
    output logic [$clog2(TABLE_SIZE)-1:0]   h_out
);
    import dhkt_pkg::*;

    localparam int R_W = $clog2(TABLE_SIZE);
    localparam int W_W = R_W + DIGIT_W;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [R_W-1:0]    r_reg, r_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [W_W-1:0]    wide;
    logic [W_W-1:0]    sub;

    // The remainder shifted by one digit stays below eight times the modulus,
    // so picking the largest multiple that fits finishes the digit.
    always_comb
    begin
        wide = {r_reg, prod_reg[PROD_W-1 -: DIGIT_W]};
        sub  = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++)
        begin
            if (wide >= W_W'(k * TABLE_SIZE))
            begin
                sub = W_W'(k * TABLE_SIZE);
            end
        end
    end

    always_comb
    begin
        prod_next = prod_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            prod_next = PROD_W'(h_in ^ HASH_W'(c)) * HASH_MUL;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = prod_reg << DIGIT_W;
            r_next    = R_W'(wide - sub);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(STEP_CNT - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_next;
            r_reg    <= r_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done  = done_reg;
    assign h_out = r_reg;

endmodule

// ----- design/dhkt_slot_mem.sv -----
// Slot stores: length and record count per slot, and the stored key words.
module dhkt_slot_mem #(
    parameter int TABLE_SIZE = 16381,
    parameter int KWW        = 3
) (
    input  logic                                     clk,
    input  logic                                     meta_we,
    input  logic [$clog2(TABLE_SIZE)-1:0]            meta_waddr,
    input  logic [dhkt_pkg::LEN_W+dhkt_pkg::COUNT_W-1:0] meta_wdata,
    input  logic [$clog2(TABLE_SIZE)-1:0]            meta_raddr,
    output logic [dhkt_pkg::LEN_W+dhkt_pkg::COUNT_W-1:0] meta_rdata,
    input  logic                                     word_we,
    input  logic [$clog2(TABLE_SIZE)+KWW-1:0]        word_addr,
    input  logic [63:0]                              word_wdata,
    output logic [63:0]                              word_rdata
);
    import dhkt_pkg::*;

    logic [LEN_W+COUNT_W-1:0] meta_mem [TABLE_SIZE];
    logic [63:0]              word_mem [TABLE_SIZE * (2 ** KWW)];

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rdata <= meta_mem[meta_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_addr] <= word_wdata;
        end
        word_rdata <= word_mem[word_addr];
    end

endmodule
